// File: hw/rtl/nat_wildcard_rule_lookup_top_assert.svh
// Assertion macros used by the NAT rule lookup top level.
`ifndef NAT_WILDCARD_RULE_LOOKUP_TOP_ASSERT_SVH
`define NAT_WILDCARD_RULE_LOOKUP_TOP_ASSERT_SVH

// Checks that cons holds at every clock edge where ante holds, outside reset.
`define NWRL_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Checks that expr holds at every clock edge outside reset.
`define NWRL_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (expr)) \
        else $error(msg);

`endif

// File: hw/rtl/nwrl_pkg.sv
// Package with the types, codes and helper function of the NAT rule lookup.
package nwrl_pkg;

    localparam int RULE_ENTRIES = 64;
    localparam int IDX_W = (RULE_ENTRIES > 1) ? $clog2(RULE_ENTRIES) : 1;

    typedef logic [IDX_W-1:0]        t_idx;
    typedef logic [RULE_ENTRIES-1:0] t_vec;
    typedef logic [1:0]              t_kind;
    typedef logic [2:0]              t_status;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam t_kind KIND_EXACT = 2'd0;
    localparam t_kind KIND_IP    = 2'd1;
    localparam t_kind KIND_PORT  = 2'd2;

    localparam t_status ST_MAPPED  = 3'd0;
    localparam t_status ST_NOMATCH = 3'd1;
    localparam t_status ST_STORED  = 3'd2;
    localparam t_status ST_FULL    = 3'd3;
    localparam t_status ST_IGNORED = 3'd4;

    typedef struct packed {
        logic found;
        t_idx idx;
    } t_pick;

    typedef struct packed {
        logic    valid;
        logic    hit;
        t_status status;
        t_idx    idx;
    } t_cam_res;

    typedef struct packed {
        logic en;
        t_idx idx;
    } t_wr_cmd;

    function automatic t_pick pri_pick(t_vec v);
        t_pick p;
        p.found = |v;
        p.idx   = '0;
        for (int i = RULE_ENTRIES - 1; i >= 0; i--) begin
            if (v[i]) begin
                p.idx = t_idx'(i);
            end
        end
        return p;
    endfunction

endpackage

// File: hw/rtl/nwrl_cam.sv
// Rule key store with parallel compare, priority pick and insert decision.
module nwrl_cam import nwrl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  logic        i_opcode,
    input  logic [31:0] i_key_ip,
    input  logic [15:0] i_key_port,
    input  logic        i_ip_is_wild,
    input  logic        i_port_is_wild,
    output t_wr_cmd     o_wr,
    output t_cam_res    o_res
);

    t_vec        r_valid;
    t_kind       r_kind       [RULE_ENTRIES];
    logic [31:0] r_match_ip   [RULE_ENTRIES];
    logic [15:0] r_match_port [RULE_ENTRIES];
    t_cam_res    r_res;
    t_cam_res    n_res;
    t_wr_cmd     wr;

    t_vec  hit_exact;
    t_vec  hit_ip;
    t_vec  hit_port;
    t_vec  ins_hits;
    t_kind ins_kind;
    t_pick ins_pick;
    t_pick free_pick;
    t_pick ex_pick;
    t_pick ip_pick;
    t_pick pt_pick;

    always_comb begin
        for (int i = 0; i < RULE_ENTRIES; i++) begin
            hit_exact[i] = r_valid[i] && (r_kind[i] == KIND_EXACT) &&
                           (r_match_ip[i] == i_key_ip) && (r_match_port[i] == i_key_port);
            hit_ip[i]    = r_valid[i] && (r_kind[i] == KIND_IP) &&
                           (r_match_ip[i] == i_key_ip);
            hit_port[i]  = r_valid[i] && (r_kind[i] == KIND_PORT) &&
                           (r_match_port[i] == i_key_port);
        end
    end

    always_comb begin
        priority if (i_ip_is_wild) begin
            ins_kind = KIND_PORT;
            ins_hits = hit_port;
        end else if (i_port_is_wild) begin
            ins_kind = KIND_IP;
            ins_hits = hit_ip;
        end else begin
            ins_kind = KIND_EXACT;
            ins_hits = hit_exact;
        end
    end

    assign ins_pick  = pri_pick(ins_hits);
    assign free_pick = pri_pick(~r_valid);
    assign ex_pick   = pri_pick(hit_exact);
    assign ip_pick   = pri_pick(hit_ip);
    assign pt_pick   = pri_pick(hit_port);

    always_comb begin
        n_res.valid  = i_valid;
        n_res.hit    = 1'b0;
        n_res.status = ST_NOMATCH;
        n_res.idx    = '0;
        wr.en        = 1'b0;
        wr.idx       = '0;
        if (i_opcode == OP_INSERT) begin
            priority if (i_ip_is_wild && i_port_is_wild) begin
                n_res.status = ST_IGNORED;
            end else if (ins_pick.found) begin
                n_res.status = ST_STORED;
                wr.en        = i_valid;
                wr.idx       = ins_pick.idx;
            end else if (free_pick.found) begin
                n_res.status = ST_STORED;
                wr.en        = i_valid;
                wr.idx       = free_pick.idx;
            end else begin
                n_res.status = ST_FULL;
            end
        end else begin
            priority if (ex_pick.found) begin
                n_res.hit    = 1'b1;
                n_res.status = ST_MAPPED;
                n_res.idx    = ex_pick.idx;
            end else if (ip_pick.found) begin
                n_res.hit    = 1'b1;
                n_res.status = ST_MAPPED;
                n_res.idx    = ip_pick.idx;
            end else if (pt_pick.found) begin
                n_res.hit    = 1'b1;
                n_res.status = ST_MAPPED;
                n_res.idx    = pt_pick.idx;
            end else begin
                n_res.status = ST_NOMATCH;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
            r_res   <= '0;
        end else begin
            if (wr.en) begin
                r_valid[wr.idx] <= 1'b1;
            end
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr.en) begin
            r_kind[wr.idx]       <= ins_kind;
            r_match_ip[wr.idx]   <= i_key_ip;
            r_match_port[wr.idx] <= i_key_port;
        end
    end

    assign o_wr  = wr;
    assign o_res = r_res;

endmodule

// File: hw/rtl/nwrl_xlat_ram.sv
// Memory of translated addresses and ports with a registered read port.
module nwrl_xlat_ram import nwrl_pkg::*; (
    input  logic        i_clk,
    input  t_wr_cmd     i_wr,
    input  logic [31:0] i_wr_ip,
    input  logic [15:0] i_wr_port,
    input  logic        i_rd_en,
    input  t_idx        i_rd_idx,
    output logic [31:0] o_rd_ip,
    output logic [15:0] o_rd_port
);

    logic [47:0] r_mem [RULE_ENTRIES];
    logic [47:0] r_rd;

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[i_wr.idx] <= {i_wr_ip, i_wr_port};
        end
        if (i_rd_en) begin
            r_rd <= r_mem[i_rd_idx];
        end else begin
            r_rd <= '0;
        end
    end

    assign o_rd_ip   = r_rd[47:16];
    assign o_rd_port = r_rd[15:0];

endmodule

// File: hw/rtl/nat_wildcard_rule_lookup_top.sv
// Top level of the NAT rule table with exact, ip-only and port-only rules.
//
// An item is transferred at a rising edge where start is high and busy is low.
// The opcode selects a rule insert or a flow lookup. busy stays low, so one
// item can be transferred in every cycle, and each item gives one result.
// The result is shown on o_status, o_mapped_ip and o_mapped_port for one cycle
// with o_valid high, after the input, key store result and output registers.
// The receiver cannot stall; results stream out at the input rate.
// The item is registered, then all rule keys are compared in parallel and a
// priority pick chooses the entry; the rule store is updated in that same
// cycle, so the next item already sees the new rule. The translated address
// and port sit in a memory whose registered read forms the last stage.
// Reset clears all rule valid bits and the pipeline; no clearing pass is run.
// Insert results carry a zero address and port, as do lookups with no match.
`include "nat_wildcard_rule_lookup_top_assert.svh"
module nat_wildcard_rule_lookup_top import nwrl_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_opcode,
    input  logic [31:0] i_key_ip,
    input  logic [15:0] i_key_port,
    input  logic        i_ip_is_wild,
    input  logic        i_port_is_wild,
    input  logic [31:0] i_new_ip,
    input  logic [15:0] i_new_port,
    output logic        o_valid,
    output logic [2:0]  o_status,
    output logic [31:0] o_mapped_ip,
    output logic [15:0] o_mapped_port
);

    logic        r_in_valid;
    logic        r_in_opcode;
    logic [31:0] r_in_key_ip;
    logic [15:0] r_in_key_port;
    logic        r_in_ip_is_wild;
    logic        r_in_port_is_wild;
    logic [31:0] r_in_new_ip;
    logic [15:0] r_in_new_port;
    logic        r_out_valid;
    t_status     r_out_status;
    t_wr_cmd     wr;
    t_cam_res    res;

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_out_status <= ST_NOMATCH;
        end else begin
            r_in_valid   <= start && !busy;
            r_out_valid  <= res.valid;
            r_out_status <= res.status;
        end
    end

    always_ff @(posedge i_clk) begin
        r_in_opcode       <= i_opcode;
        r_in_key_ip       <= i_key_ip;
        r_in_key_port     <= i_key_port;
        r_in_ip_is_wild   <= i_ip_is_wild;
        r_in_port_is_wild <= i_port_is_wild;
        r_in_new_ip       <= i_new_ip;
        r_in_new_port     <= i_new_port;
    end

    nwrl_cam u_cam (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (r_in_valid),
        .i_opcode       (r_in_opcode),
        .i_key_ip       (r_in_key_ip),
        .i_key_port     (r_in_key_port),
        .i_ip_is_wild   (r_in_ip_is_wild),
        .i_port_is_wild (r_in_port_is_wild),
        .o_wr           (wr),
        .o_res          (res)
    );

    nwrl_xlat_ram u_xlat_ram (
        .i_clk     (i_clk),
        .i_wr      (wr),
        .i_wr_ip   (r_in_new_ip),
        .i_wr_port (r_in_new_port),
        .i_rd_en   (res.valid && res.hit),
        .i_rd_idx  (res.idx),
        .o_rd_ip   (o_mapped_ip),
        .o_rd_port (o_mapped_port)
    );

    assign o_valid  = r_out_valid;
    assign o_status = r_out_status;

    `NWRL_ASSERT_IMP(a_latency,
        $past(i_rst_n, 1) && $past(i_rst_n, 2) && $past(i_rst_n, 3),
        o_valid == $past(start && !busy, 3),
        "result strobe does not follow the transfer by three cycles")
    `NWRL_ASSERT_IMP(a_zero_unmapped,
        o_valid && (o_status != ST_MAPPED),
        (o_mapped_ip == 32'd0) && (o_mapped_port == 16'd0),
        "unmapped result carries a nonzero translation")
    `NWRL_ASSERT_IMP(a_insert_status,
        o_valid && ($past(i_opcode, 3) == OP_INSERT),
        (o_status == ST_STORED) || (o_status == ST_FULL) || (o_status == ST_IGNORED),
        "insert gave a lookup status")

endmodule
